// ===== hw/rtl/dpx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpx_pkg
// Shared widths, configuration codes and the queue item of the depth pixel
// to xyz point converter.
// ----------------------------------------------------------------------------
package dpx_pkg;

  // frame geometry
  localparam int unsigned MAX_FRAME_DIM = 2048;
  localparam int unsigned CNT_W         = $clog2(MAX_FRAME_DIM);
  localparam int unsigned DIM_W         = CNT_W + 1;
  localparam int unsigned COORD_W       = CNT_W + 1;

  // field widths
  localparam int unsigned SIZE_W      = 12;
  localparam int unsigned DEPTH_W     = 16;
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned IFOC_W      = 24;
  localparam int unsigned IFOC_HALF_W = IFOC_W / 2;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned XY_W        = 35;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  // product widths: |coord| * depth, then times one half of inverse_focal
  localparam int unsigned P1_W       = CNT_W + DEPTH_W;
  localparam int unsigned P2_W       = P1_W + IFOC_HALF_W;
  localparam int unsigned PROD_W     = P1_W + IFOC_W;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned RND_W      = PROD_W + 1 - FRAC_SHIFT;

  // front to back queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_NO_SAMPLE     = 3'd2,
    CFG_SHADOW        = 3'd3,
    CFG_INVERSE_FOCAL = 3'd4
  } cfg_index_e;

  // settings the front end classifies with
  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [CODE_W-1:0] no_sample_code;
    logic [CODE_W-1:0] shadow_code;
  } front_cfg_t;

  // one classified pixel
  typedef struct packed {
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic [DEPTH_W-1:0] depth;
    logic               pt_valid;
    logic               frame_end;
    logic [COLOR_W-1:0] color;
  } item_t;

endpackage

// ===== hw/rtl/dpx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpx_front
// Accepts raster pixels, tracks column and row, computes centred coordinates,
// validity, end of frame and packed colour, and pushes the result to the queue.
// ----------------------------------------------------------------------------
module dpx_front import dpx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  front_cfg_t         cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [DEPTH_W-1:0] depth_mm_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output item_t              item_o
);

  // clamp to 2..MAX_FRAME_DIM and force even
  function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [DIM_W-1:0] s;
    if (int'(r) < 2) begin
      s = DIM_W'(2);
    end else if (int'(r) > int'(MAX_FRAME_DIM)) begin
      s = DIM_W'(MAX_FRAME_DIM);
    end else begin
      s = DIM_W'(r);
    end
    s[0] = 1'b0;
    return s;
  endfunction

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, last_row;
  logic             depth_ok;

  assign w_eff    = eff_size(cfg_i.frame_width);
  assign h_eff    = eff_size(cfg_i.frame_height);
  assign col_inc  = {1'b0, col_q} + DIM_W'(1);
  assign row_inc  = {1'b0, row_q} + DIM_W'(1);
  assign row_end  = col_inc >= w_eff;
  assign last_row = row_inc >= h_eff;

  // zero and the two sensor codes mark a missing sample
  assign depth_ok = (depth_mm_i != '0) && (depth_mm_i != cfg_i.no_sample_code)
                    && (depth_mm_i != cfg_i.shadow_code);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classified beat
  always_comb begin
    item_o.u         = {1'b0, col_q} - (w_eff >> 1);
    item_o.v         = {1'b0, row_q} - (h_eff >> 1);
    item_o.depth     = depth_mm_i;
    item_o.pt_valid  = depth_ok;
    item_o.frame_end = row_end && last_row;
    item_o.color     = {red_in_i, green_in_i, blue_in_i};
  end

  // raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hw/rtl/dpx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpx_queue
// Small first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module dpx_queue import dpx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W + 1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/dpx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpx_back
// Projection pipeline: |coord| * depth, times the two halves of inverse_focal,
// sum and round to Q.8, then saturate, apply sign, zero a missing sample and register the result.
// ----------------------------------------------------------------------------
module dpx_back import dpx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IFOC_W-1:0]   ifoc_i,
  input  logic                q_empty_i,
  input  item_t               item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [XY_W-1:0]     x_q8_o,
  output logic [XY_W-1:0]     y_q8_o,
  output logic [DEPTH_W-1:0]  z_mm_o,
  output logic                point_valid_o,
  output logic [COLOR_W-1:0]  packed_color_o,
  output logic                frame_end_o
);

  // fields that ride along the pipeline unchanged
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               pt_valid;
    logic               frame_end;
    logic [COLOR_W-1:0] color;
    logic [1:0]         neg;
  } side_t;

  localparam logic [RND_W-1:0] POS_MAX = RND_W'((64'd1 << (XY_W - 1)) - 64'd1);
  localparam logic [RND_W-1:0] NEG_MAG = RND_W'(64'd1 << (XY_W - 1));
  localparam logic [PROD_W:0]  HALF_LSB = (PROD_W + 1)'(64'd1 << (FRAC_SHIFT - 1));

  logic adv;

  logic                  s1_v_q, s2_v_q, s3_v_q, out_v_q;
  side_t                 s1_side_q, s2_side_q, s3_side_q;
  side_t                 s1_side_d;
  logic [1:0][P1_W-1:0]  s1_p_q, s1_p_d;
  logic [1:0][P2_W-1:0]  s2_lo_q, s2_hi_q, s2_lo_d, s2_hi_d;
  logic [1:0][RND_W-1:0] s3_r_q, s3_r_d;
  logic [1:0][XY_W-1:0]  out_xy_d;
  logic [1:0][COORD_W-1:0] coord;
  logic [1:0][COORD_W-1:0] coord_neg;
  logic [1:0][CNT_W-1:0]   mag;
  logic [1:0][PROD_W:0]    sum;
  logic [1:0][RND_W-1:0]   sat;

  // whole pipeline moves unless the output register holds an untaken beat
  assign adv         = !out_v_q || out_ready_i;
  assign pop_o       = adv && !q_empty_i;
  assign out_valid_o = out_v_q;

  // stage 1: magnitude of each coordinate times depth
  always_comb begin
    coord[0] = item_i.u;
    coord[1] = item_i.v;
    for (int i = 0; i < 2; i++) begin
      coord_neg[i] = -coord[i];
      mag[i]       = coord[i][COORD_W-1] ? coord_neg[i][CNT_W-1:0] : coord[i][CNT_W-1:0];
      s1_p_d[i]    = P1_W'(mag[i]) * P1_W'(item_i.depth);
    end
    s1_side_d.depth     = item_i.depth;
    s1_side_d.pt_valid  = item_i.pt_valid;
    s1_side_d.frame_end = item_i.frame_end;
    s1_side_d.color     = item_i.color;
    s1_side_d.neg       = {coord[1][COORD_W-1], coord[0][COORD_W-1]};
  end

  // stage 2: partial products against the low and high halves of inverse_focal
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s2_lo_d[i] = P2_W'(s1_p_q[i]) * P2_W'(ifoc_i[IFOC_HALF_W-1:0]);
      s2_hi_d[i] = P2_W'(s1_p_q[i]) * P2_W'(ifoc_i[IFOC_W-1:IFOC_HALF_W]);
    end
  end

  // stage 3: combine, round half away from zero on the magnitude, drop to Q.8
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sum[i]    = (PROD_W + 1)'(s2_lo_q[i]) + ((PROD_W + 1)'(s2_hi_q[i]) << IFOC_HALF_W)
                  + HALF_LSB;
      s3_r_d[i] = sum[i][PROD_W:FRAC_SHIFT];
    end
  end

  // stage 4: saturate, apply sign, zero for a missing sample
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (s3_side_q.neg[i]) begin
        sat[i]      = (s3_r_q[i] > NEG_MAG) ? NEG_MAG : s3_r_q[i];
        out_xy_d[i] = XY_W'(-sat[i]);
      end else begin
        sat[i]      = (s3_r_q[i] > POS_MAX) ? POS_MAX : s3_r_q[i];
        out_xy_d[i] = XY_W'(sat[i]);
      end
      if (!s3_side_q.pt_valid) begin
        out_xy_d[i] = '0;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= !q_empty_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_p_q         <= s1_p_d;
      s1_side_q      <= s1_side_d;
      s2_lo_q        <= s2_lo_d;
      s2_hi_q        <= s2_hi_d;
      s2_side_q      <= s1_side_q;
      s3_r_q         <= s3_r_d;
      s3_side_q      <= s2_side_q;
      x_q8_o         <= out_xy_d[0];
      y_q8_o         <= out_xy_d[1];
      z_mm_o         <= s3_side_q.pt_valid ? s3_side_q.depth : '0;
      point_valid_o  <= s3_side_q.pt_valid;
      packed_color_o <= s3_side_q.color;
      frame_end_o    <= s3_side_q.frame_end;
    end
  end

endmodule

// ===== hw/rtl/depth_pixel_to_xyz_point.sv =====
`timescale 1ns / 1ps
// Path: an accepted input beat is written into the queue, then runs through the
//   four stages of the multiply pipeline, the last of them the output register.
// Throughput: one pixel per cycle while output beats are taken, set by the fully pipelined multipliers;
//   a four-entry queue lets the front keep accepting while the output stalls, until it fills.
// Reset: counters, queue and pipeline valids clear; registers take their defaults.
// ----------------------------------------------------------------------------
// depth_pixel_to_xyz_point
// Back-projects raster depth pixels through a pinhole model into XYZ points
// with X and Y in mm Q.8, Z in whole mm, and packed colour.
// ----------------------------------------------------------------------------
module depth_pixel_to_xyz_point import dpx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DEPTH_W-1:0]    depth_mm_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [XY_W-1:0] x_q8_o,
  output logic signed [XY_W-1:0] y_q8_o,
  output logic [DEPTH_W-1:0]    z_mm_o,
  output logic                  point_valid_o,
  output logic [COLOR_W-1:0]    packed_color_o,
  output logic                  frame_end_o
);

  front_cfg_t        cfg_q;
  logic [IFOC_W-1:0] ifoc_q;
  logic              push, pop, q_full, q_empty;
  item_t             push_item, pop_item;
  logic [XY_W-1:0]   x_raw, y_raw;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= SIZE_W'(640);
      cfg_q.frame_height   <= SIZE_W'(480);
      cfg_q.no_sample_code <= '0;
      cfg_q.shadow_code    <= '0;
      ifoc_q               <= IFOC_W'(31957);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:   cfg_q.frame_width    <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT:  cfg_q.frame_height   <= cfg_data_i[SIZE_W-1:0];
        CFG_NO_SAMPLE:     cfg_q.no_sample_code <= cfg_data_i[CODE_W-1:0];
        CFG_SHADOW:        cfg_q.shadow_code    <= cfg_data_i[CODE_W-1:0];
        CFG_INVERSE_FOCAL: ifoc_q               <= cfg_data_i[IFOC_W-1:0];
        default: ;
      endcase
    end
  end

  // front end: counters and classification
  dpx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .depth_mm_i (depth_mm_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // decoupling queue
  dpx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  // back end: projection pipeline and output register
  dpx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ifoc_i         (ifoc_q),
    .q_empty_i      (q_empty),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .x_q8_o         (x_raw),
    .y_q8_o         (y_raw),
    .z_mm_o         (z_mm_o),
    .point_valid_o  (point_valid_o),
    .packed_color_o (packed_color_o),
    .frame_end_o    (frame_end_o)
  );

  assign x_q8_o = $signed(x_raw);
  assign y_q8_o = $signed(y_raw);

  // a missing sample leaves a point at the origin
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> (x_q8_o == '0) && (y_q8_o == '0) && (z_mm_o == '0))
    else $error("invalid point with nonzero coordinates");

  // a real measurement never carries the reserved depth codes
  a_valid_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_valid_o |->
      (z_mm_o != '0) && (z_mm_o != cfg_q.no_sample_code) && (z_mm_o != cfg_q.shadow_code))
    else $error("valid point with reserved depth");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("push into full queue");

  // an accepted beat sits in the queue on the next cycle
  a_out_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !q_empty)
    else $error("accepted beat missing from queue");

endmodule

// ===== tb/tb_depth_pixel_to_xyz_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_to_xyz_point
// Streams raster depth pixels through the converter under several register
// settings and random handshake gaps on both sides. Every output beat is
// checked field by field against an in-order queue of expected points that a
// local back-projection predictor fills as input beats are accepted.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_xyz_point;
  import dpx_pkg::*;

  localparam int DUT_LATENCY = 4;
  localparam int TIMEOUT_NS  = 2_000_000;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_BEATS = 90;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam logic [63:0] XY_POS_MAX = (64'd1 << (XY_W - 1)) - 64'd1;
  localparam logic [63:0] XY_NEG_MAG = 64'd1 << (XY_W - 1);
  localparam logic [IFOC_W-1:0] IFOC_MAX = '1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [DEPTH_W-1:0]     z;
    logic                   pt_valid;
    logic [COLOR_W-1:0]     color;
    logic                   frame_end;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // pixel and point channels
  logic   in_valid = 1'b0;
  logic   in_ready_o;
  pixel_t in_pixel = '0;
  logic   out_valid_o;
  logic   out_ready = 1'b0;
  logic signed [XY_W-1:0] x_q8_o;
  logic signed [XY_W-1:0] y_q8_o;
  logic [DEPTH_W-1:0]     z_mm_o;
  logic                   point_valid_o;
  logic [COLOR_W-1:0]     packed_color_o;
  logic                   frame_end_o;

  // predictor copy of registers and raster counters
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [CODE_W-1:0] no_sample_reg;
  logic [CODE_W-1:0] shadow_reg;
  logic [IFOC_W-1:0] ifoc_reg;
  int column_cnt;
  int row_cnt;

  pixel_t pixel_queue[$];
  point_t expected_points[$];
  int     pixels_issued = 0;
  int     pixels_accepted = 0;
  int     error_cnt = 0;
  bit     beat_taken = 1'b0;
  int     send_idle_pct = 10;
  int     recv_idle_pct = 71;

  depth_pixel_to_xyz_point dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .depth_mm_i     (in_pixel.depth),
    .red_in_i       (in_pixel.red),
    .green_in_i     (in_pixel.green),
    .blue_in_i      (in_pixel.blue),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .x_q8_o         (x_q8_o),
    .y_q8_o         (y_q8_o),
    .z_mm_o         (z_mm_o),
    .point_valid_o  (point_valid_o),
    .packed_color_o (packed_color_o),
    .frame_end_o    (frame_end_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // effective frame dimension: clamped to 2..MAX_FRAME_DIM, bit 0 dropped
  function automatic int frame_size(input logic [SIZE_W-1:0] reg_val);
    int s;
    s = int'(reg_val);
    if (s < 2) s = 2;
    if (s > MAX_FRAME_DIM) s = MAX_FRAME_DIM;
    return s & ~1;
  endfunction

  // coord * depth * inverse focal, Q.24 to Q.8, round half away, saturate
  function automatic logic [XY_W-1:0] scale_to_q8(input int coord,
                                                  input logic [DEPTH_W-1:0] depth);
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] r;
    mag  = (coord < 0) ? 64'(-coord) : 64'(coord);
    prod = mag * 64'(depth) * 64'(ifoc_reg);
    r    = (prod + 64'd32768) >> 16;
    if (coord < 0) begin
      if (r > XY_NEG_MAG) r = XY_NEG_MAG;
      r = 64'd0 - r;
    end else if (r > XY_POS_MAX) begin
      r = XY_POS_MAX;
    end
    return r[XY_W-1:0];
  endfunction

  // back-project one pixel and advance the raster counters
  function automatic point_t back_project(input pixel_t p);
    point_t pt;
    int     w;
    int     h;
    int     u;
    int     v;
    logic   ok;
    logic   row_end;
    logic   last_row;
    w  = frame_size(width_reg);
    h  = frame_size(height_reg);
    u  = column_cnt - w / 2;
    v  = row_cnt - h / 2;
    ok = (p.depth != 0) && (p.depth != no_sample_reg) && (p.depth != shadow_reg);
    row_end  = (column_cnt + 1 >= w);
    last_row = (row_cnt + 1 >= h);
    pt.x         = ok ? scale_to_q8(u, p.depth) : '0;
    pt.y         = ok ? scale_to_q8(v, p.depth) : '0;
    pt.z         = ok ? p.depth : '0;
    pt.pt_valid  = ok;
    pt.color     = {p.red, p.green, p.blue};
    pt.frame_end = row_end && last_row;
    if (row_end) begin
      column_cnt = 0;
      row_cnt    = last_row ? 0 : row_cnt + 1;
    end else begin
      column_cnt = column_cnt + 1;
    end
    return pt;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      error_cnt++;
    end
  endfunction

  // input acceptance feeds the predictor; output beats are checked in order
  always @(posedge clk_i) begin
    point_t exp_pt;
    if (in_valid && in_ready_o) begin
      expected_points.push_back(back_project(in_pixel));
      pixels_accepted++;
      beat_taken = 1'b1;
    end
    if (out_valid_o && out_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: point beat with none expected, expected nothing actual x=%h y=%h z=%h",
                 $time, x_q8_o, y_q8_o, z_mm_o);
        error_cnt++;
      end else begin
        exp_pt = expected_points.pop_front();
        check_field("x_q8", 64'(exp_pt.x), 64'(x_q8_o));
        check_field("y_q8", 64'(exp_pt.y), 64'(y_q8_o));
        check_field("z_mm", 64'(exp_pt.z), 64'(z_mm_o));
        check_field("point_valid", 64'(exp_pt.pt_valid), 64'(point_valid_o));
        check_field("packed_color", 64'(exp_pt.color), 64'(packed_color_o));
        check_field("frame_end", 64'(exp_pt.frame_end), 64'(frame_end_o));
      end
    end
  end

  // pixel driver and point receiver, both on the falling edge
  always @(negedge clk_i) begin
    logic   holding;
    pixel_t nxt;
    holding    = in_valid && !beat_taken;
    beat_taken = 1'b0;
    if (!holding) begin
      if (rst_ni && pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pixel_queue.pop_front();
        in_pixel <= nxt;
        in_valid <= 1'b1;
        pixels_issued++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:   width_reg     = data[SIZE_W-1:0];
      CFG_FRAME_HEIGHT:  height_reg    = data[SIZE_W-1:0];
      CFG_NO_SAMPLE:     no_sample_reg = data[CODE_W-1:0];
      CFG_SHADOW:        shadow_reg    = data[CODE_W-1:0];
      CFG_INVERSE_FOCAL: ifoc_reg      = data[IFOC_W-1:0];
      default: ;
    endcase
  endtask

  // block until every queued pixel has come back out, then let the pipe settle
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || pixels_issued != pixels_accepted ||
           expected_points.size() != 0)
      @(posedge clk_i);
    repeat (DUT_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic push_pixel(input logic [DEPTH_W-1:0] depth, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    pixel_queue.push_back({depth, r, g, b});
  endtask

  // depth mix leans on the invalid codes and the range ends
  function automatic pixel_t random_pixel();
    pixel_t p;
    case ($urandom_range(0, 7))
      0: p.depth = '0;
      1: p.depth = no_sample_reg;
      2: p.depth = shadow_reg;
      3: p.depth = DEPTH_W'($urandom_range(1, 255));
      4: p.depth = '1;
      default: p.depth = DEPTH_W'($urandom_range(0, 65535));
    endcase
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    return p;
  endfunction

  // mostly small frames, now and then a wide or out-of-range one
  function automatic logic [CFG_DATA_W-1:0] random_size();
    logic [SIZE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: s = SIZE_W'($urandom_range(2048, 4095));
      1: s = SIZE_W'($urandom_range(0, 4095));
      default: s = SIZE_W'($urandom_range(0, 16));
    endcase
    return {12'($urandom), s};
  endfunction

  task automatic configure_phase(input int phase);
    logic [CODE_W-1:0] ns_code;
    logic [CODE_W-1:0] sh_code;
    logic [IFOC_W-1:0] ifoc;
    ns_code = CODE_W'($urandom);
    sh_code = CODE_W'($urandom);
    case ($urandom_range(0, 3))
      0: ifoc = IFOC_W'(31957);
      1: ifoc = IFOC_W'($urandom_range(0, 255));
      default: ifoc = IFOC_W'($urandom);
    endcase
    // pin the code and focal extremes in the first phases
    if (phase == 0) begin
      ns_code = '0;
      sh_code = '1;
      ifoc    = '0;
    end else if (phase == 1) begin
      ns_code = '1;
      sh_code = '0;
      ifoc    = IFOC_MAX;
    end
    if (phase == 2) begin
      write_reg(CFG_FRAME_WIDTH, {12'($urandom), 12'd1});
      write_reg(CFG_FRAME_HEIGHT, {12'($urandom), 12'd0});
    end else begin
      write_reg(CFG_FRAME_WIDTH, random_size());
      write_reg(CFG_FRAME_HEIGHT, random_size());
    end
    write_reg(CFG_NO_SAMPLE, {8'($urandom), ns_code});
    write_reg(CFG_SHADOW, {8'($urandom), sh_code});
    write_reg(CFG_INVERSE_FOCAL, ifoc);
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
  endtask

  // stimulus
  initial begin
    width_reg     = SIZE_W'(640);
    height_reg    = SIZE_W'(480);
    no_sample_reg = '0;
    shadow_reg    = '0;
    ifoc_reg      = IFOC_W'(31957);
    column_cnt    = 0;
    row_cnt       = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register defaults straight out of reset
    push_pixel('1, 8'hff, 8'hff, 8'hff);
    push_pixel('0, 8'h00, 8'h00, 8'h00);
    push_pixel(16'd1000, 8'h12, 8'h34, 8'h56);
    wait_idle();

    // tiny frame, both invalid codes, max inverse focal; counters carry over
    write_reg(CFG_FRAME_WIDTH, 24'd4);
    write_reg(CFG_FRAME_HEIGHT, 24'd2);
    write_reg(CFG_NO_SAMPLE, 24'd1234);
    write_reg(CFG_SHADOW, 24'd4321);
    write_reg(CFG_INVERSE_FOCAL, IFOC_MAX);
    write_reg(CFG_UNUSED_IDX, '1);
    push_pixel(16'd1234, 8'hff, 8'h00, 8'hff);
    push_pixel(16'd4321, 8'h00, 8'hff, 8'h00);
    push_pixel('0, 8'haa, 8'h55, 8'haa);
    push_pixel('1, 8'h55, 8'haa, 8'h55);
    push_pixel(16'd1, 8'hff, 8'hff, 8'hff);
    push_pixel('1, 8'h00, 8'h00, 8'h00);
    push_pixel(16'h8000, 8'h80, 8'h01, 8'hfe);
    push_pixel(16'd1, 8'h7f, 8'h80, 8'h01);
    wait_idle();

    // oversized width and odd height, then shrink the width mid-row
    write_reg(CFG_FRAME_WIDTH, 24'd4095);
    write_reg(CFG_FRAME_HEIGHT, 24'd3);
    repeat (5) pixel_queue.push_back(random_pixel());
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 24'd2);
    push_pixel('1, 8'hff, 8'h00, 8'h00);
    push_pixel('1, 8'h00, 8'hff, 8'h00);
    push_pixel(16'd777, 8'h00, 8'h00, 8'hff);
    wait_idle();

    // random phases under changing settings and handshake pressure
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 71;
        recv_idle_pct = 10;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure_phase(ph);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        pixel_queue.push_back(random_pixel());
        // let the pipe run dry once in the middle of a phase
        if (ph == 3 && i == PHASE_BEATS / 2)
          wait_idle();
      end
      wait_idle();
    end

    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
